[sv/e2u_pkg.sv]
// Shared types, constants and helper functions for the epoch-to-calendar block.
package e2u_pkg;

    // Stream widths: payload fields padded up to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    // Divisors used to rebuild each remainder from its quotient.
    localparam logic [16:0] DAY_SECS  = 17'd86400;
    localparam logic [11:0] HOUR_SECS = 12'd3600;
    localparam logic [5:0]  MIN_SECS  = 6'd60;

    // Reciprocal multipliers of the constant divisions. Each quotient is
    // (x * RECIP) >> SHIFT, exact over the whole range of x: seconds / 128
    // over 675 for days, days over 7 for the week, second of day / 16 over
    // 225 for hours and second of hour / 4 over 15 for minutes.
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;
    localparam int          DAY_SHIFT  = 35;
    localparam logic [16:0] WEEK_RECIP = 17'd74899;
    localparam int          WEEK_SHIFT = 19;
    localparam logic [13:0] HOUR_RECIP = 14'd9321;
    localparam int          HOUR_SHIFT = 21;
    localparam logic [10:0] MIN_RECIP  = 11'd1093;
    localparam int          MIN_SHIFT  = 14;

    // Calendar constants, years counted from 1900.
    localparam logic [7:0] FIRST_YEAR_OFS = 8'd70;
    localparam logic [7:0] YEAR_2100_OFS  = 8'd200;
    localparam logic [2:0] EPOCH_WDAY     = 3'd4;
    localparam logic [3:0] MONTH_FEB      = 4'd1;
    localparam logic [3:0] MONTH_DEC      = 4'd11;
    localparam logic [8:0] YEAR_DAYS      = 9'd365;
    localparam logic [8:0] LEAP_YEAR_DAYS = 9'd366;
    localparam logic [2:0] WEEK_DAYS      = 3'd7;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DAY,
        ST_SOD,
        ST_HOUR,
        ST_HREM,
        ST_MIN,
        ST_MFIN,
        ST_YEAR,
        ST_MONTH,
        ST_DONE
    } e2u_state_t;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DAY_DIV,
        OP_DAY_REM,
        OP_HOUR_DIV,
        OP_HOUR_REM,
        OP_MIN_DIV,
        OP_MIN_DONE,
        OP_YEAR_STEP,
        OP_MONTH_STEP,
        OP_PUBLISH
    } e2u_op_t;

    typedef struct packed {
        e2u_op_t op;
    } e2u_cmd_t;

    typedef struct packed {
        logic year_fit;
        logic month_fit;
        logic out_free;
    } e2u_sts_t;

    // Days in a month, February stretched in a leap year.
    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        unique case (mon)
            MONTH_FEB:           len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8,
            4'd10:               len = 5'd30;
            default:             len = 5'd31;
        endcase
        return len;
    endfunction

    // Gregorian rule over 1970..2106: the only century years in range are
    // 2000 (leap) and 2100 (not leap), and 1900 is a multiple of four.
    function automatic logic is_leap(input logic [7:0] yofs);
        return (yofs[1:0] == 2'b00) && (yofs != YEAR_2100_OFS);
    endfunction

endpackage

[sv/epoch_seconds_to_utc_calendar.sv]
// Top level: Unix timestamp to broken-down UTC calendar time.
//
// The slave channel takes one signed 33-bit count of seconds since
// 1970-01-01 00:00:00 UTC per item; a negative count is read as zero.
// The master channel returns one calendar item per input item.
// An item is taken at a clock edge where tvalid and tready are both high.
// After acceptance the item is worked on in order: constant division by
// reciprocal multiplication for days, second of day, hour and minute, each
// quotient followed by its remainder; then the years and the months are
// peeled off one at a time until each fits, where Y is the year minus 1970
// (0..136) and M the month index (0..11), and Y + M never exceeds 146; last
// the output register is loaded. The block takes the next item only once it
// is back in idle after publishing, so only one item is in work at a time.
// The result sits in an output register; a new item can be accepted and
// worked on while the previous result waits, and the block only holds at the
// end of the next item until the receiver takes the waiting one.
// Reset (aresetn low, synchronous) returns the controller to idle and drops
// any result not yet taken.
module epoch_seconds_to_utc_calendar (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [32:0] epoch_seconds, [39:33] zero
    input  logic [e2u_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [5:0] second, [11:6] minute, [16:12] hour, [19:17] weekday,
    // [27:20] years_since_1900, [36:28] day_of_year, [40:37] month_index,
    // [45:41] day_of_month, [47:46] zero
    output logic [e2u_pkg::M_TDATA_W-1:0] m_tdata
);

    e2u_pkg::e2u_cmd_t cmd;
    e2u_pkg::e2u_sts_t sts;

    e2u_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    e2u_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .epoch_seconds (s_tdata[32:0]),
        .cmd           (cmd),
        .sts           (sts),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_tdata       (m_tdata)
    );

    // An accepted item keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // A published result shows up on the master side.
    a_publish_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == e2u_pkg::OP_PUBLISH |=> m_tvalid)
        else $error("published result not presented");

    // Publishing never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == e2u_pkg::OP_PUBLISH |-> !m_tvalid || m_tready)
        else $error("waiting result overwritten");

    // Every presented result holds in-range second, minute, hour, weekday, month and day-of-month fields.
    a_fields_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[5:0] < 6'd60) && (m_tdata[11:6] < 6'd60)
                  && (m_tdata[16:12] < 5'd24) && (m_tdata[19:17] < 3'd7)
                  && (m_tdata[40:37] < 4'd12) && (m_tdata[45:41] != 5'd0))
        else $error("result field out of range");

endmodule

[sv/e2u_ctrl.sv]
// Sequencing state machine of the epoch-to-calendar block.
module e2u_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  e2u_pkg::e2u_sts_t sts,
    output e2u_pkg::e2u_cmd_t cmd
);

    e2u_pkg::e2u_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= e2u_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state: the fixed division states, then the year and month loops, then publishing.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            e2u_pkg::ST_IDLE:  if (s_tvalid) state_next = e2u_pkg::ST_DAY;
            e2u_pkg::ST_DAY:   state_next = e2u_pkg::ST_SOD;
            e2u_pkg::ST_SOD:   state_next = e2u_pkg::ST_HOUR;
            e2u_pkg::ST_HOUR:  state_next = e2u_pkg::ST_HREM;
            e2u_pkg::ST_HREM:  state_next = e2u_pkg::ST_MIN;
            e2u_pkg::ST_MIN:   state_next = e2u_pkg::ST_MFIN;
            e2u_pkg::ST_MFIN:  state_next = e2u_pkg::ST_YEAR;
            e2u_pkg::ST_YEAR:  if (sts.year_fit) state_next = e2u_pkg::ST_MONTH;
            e2u_pkg::ST_MONTH: if (sts.month_fit) state_next = e2u_pkg::ST_DONE;
            e2u_pkg::ST_DONE:  if (sts.out_free) state_next = e2u_pkg::ST_IDLE;
            default:           state_next = e2u_pkg::ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        s_tready = (state_reg == e2u_pkg::ST_IDLE);
        cmd.op   = e2u_pkg::OP_NONE;
        unique case (state_reg)
            e2u_pkg::ST_IDLE:  if (s_tvalid) cmd.op = e2u_pkg::OP_LOAD;
            e2u_pkg::ST_DAY:   cmd.op = e2u_pkg::OP_DAY_DIV;
            e2u_pkg::ST_SOD:   cmd.op = e2u_pkg::OP_DAY_REM;
            e2u_pkg::ST_HOUR:  cmd.op = e2u_pkg::OP_HOUR_DIV;
            e2u_pkg::ST_HREM:  cmd.op = e2u_pkg::OP_HOUR_REM;
            e2u_pkg::ST_MIN:   cmd.op = e2u_pkg::OP_MIN_DIV;
            e2u_pkg::ST_MFIN:  cmd.op = e2u_pkg::OP_MIN_DONE;
            e2u_pkg::ST_YEAR:  cmd.op = e2u_pkg::OP_YEAR_STEP;
            e2u_pkg::ST_MONTH: cmd.op = e2u_pkg::OP_MONTH_STEP;
            e2u_pkg::ST_DONE:  if (sts.out_free) cmd.op = e2u_pkg::OP_PUBLISH;
            default:           cmd.op = e2u_pkg::OP_NONE;
        endcase
    end

endmodule

[sv/e2u_dpath.sv]
// Datapath: reciprocal-multiply divisions, year and month peeling, output register.
module e2u_dpath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [32:0]                     epoch_seconds,
    input  e2u_pkg::e2u_cmd_t               cmd,
    output e2u_pkg::e2u_sts_t               sts,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [e2u_pkg::M_TDATA_W-1:0]   m_tdata
);

    // Division registers: clamped seconds, week quotient, second of day and of hour.
    logic [31:0] t_reg, t_next;
    logic [13:0] wk_quo_reg, wk_quo_next;
    logic [16:0] sod_reg, sod_next;
    logic [11:0] soh_reg, soh_next;
    // Calendar registers.
    logic [15:0] days_reg, days_next;
    logic [7:0]  year_reg, year_next;
    logic [8:0]  yday_reg, yday_next;
    logic [3:0]  mon_reg, mon_next;
    logic [5:0]  sec_reg, sec_next;
    logic [5:0]  min_reg, min_next;
    logic [4:0]  hour_reg, hour_next;
    logic [2:0]  wday_reg, wday_next;
    // Output register.
    logic                          out_valid_reg, out_valid_next;
    logic [e2u_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic [31:0] t_clamp;
    logic [50:0] day_prod;
    logic [32:0] day_back;
    logic [32:0] week_prod;
    logic [15:0] week_back;
    logic [26:0] hour_prod;
    logic [16:0] hour_back;
    logic [20:0] min_prod;
    logic [11:0] min_back;
    logic [3:0]  wday_sum;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic [4:0]  dom;

    // A negative timestamp counts as the epoch itself.
    assign t_clamp = epoch_seconds[32] ? 32'd0 : epoch_seconds[31:0];

    // Quotients by reciprocal multiplication, remainders by multiply and subtract.
    // The power-of-two part of each divisor is dropped first as a plain shift.
    assign day_prod  = 51'(t_reg[31:7]) * 51'(e2u_pkg::DAY_RECIP);
    assign day_back  = 33'(days_reg) * 33'(e2u_pkg::DAY_SECS);
    assign week_prod = 33'(days_reg) * 33'(e2u_pkg::WEEK_RECIP);
    assign week_back = 16'(wk_quo_reg) * 16'(e2u_pkg::WEEK_DAYS);
    assign hour_prod = 27'(sod_reg[16:4]) * 27'(e2u_pkg::HOUR_RECIP);
    assign hour_back = 17'(hour_reg) * 17'(e2u_pkg::HOUR_SECS);
    assign min_prod  = 21'(soh_reg[11:2]) * 21'(e2u_pkg::MIN_RECIP);
    assign min_back  = 12'(min_reg) * 12'(e2u_pkg::MIN_SECS);

    // Day of week: the day count modulo seven, shifted to a Thursday start.
    assign wday_sum = {1'b0, wday_reg} + {1'b0, e2u_pkg::EPOCH_WDAY};

    // Year and month lengths for the current position.
    assign leap = e2u_pkg::is_leap(year_reg);
    assign ylen = leap ? e2u_pkg::LEAP_YEAR_DAYS : e2u_pkg::YEAR_DAYS;
    assign mlen = e2u_pkg::month_len(mon_reg, leap);
    assign dom  = days_reg[4:0] + 5'd1;

    assign sts.year_fit  = (days_reg < {7'd0, ylen});
    assign sts.month_fit = (mon_reg == e2u_pkg::MONTH_DEC) || (days_reg < {11'd0, mlen});
    assign sts.out_free  = !out_valid_reg || m_tready;

    // Next values by operation.
    always_comb begin
        t_next         = t_reg;
        wk_quo_next    = wk_quo_reg;
        sod_next       = sod_reg;
        soh_next       = soh_reg;
        days_next      = days_reg;
        year_next      = year_reg;
        yday_next      = yday_reg;
        mon_next       = mon_reg;
        sec_next       = sec_reg;
        min_next       = min_reg;
        hour_next      = hour_reg;
        wday_next      = wday_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        case (cmd.op)
            e2u_pkg::OP_LOAD: begin
                t_next = t_clamp;
            end
            e2u_pkg::OP_DAY_DIV: begin
                days_next = day_prod[e2u_pkg::DAY_SHIFT +: 16];
            end
            e2u_pkg::OP_DAY_REM: begin
                sod_next    = 17'(t_reg - day_back[31:0]);
                wk_quo_next = week_prod[e2u_pkg::WEEK_SHIFT +: 14];
            end
            e2u_pkg::OP_HOUR_DIV: begin
                hour_next = hour_prod[e2u_pkg::HOUR_SHIFT +: 5];
                wday_next = 3'(days_reg - week_back);
            end
            e2u_pkg::OP_HOUR_REM: begin
                soh_next  = 12'(sod_reg - hour_back);
                wday_next = (wday_sum >= {1'b0, e2u_pkg::WEEK_DAYS})
                          ? 3'(wday_sum - {1'b0, e2u_pkg::WEEK_DAYS}) : wday_sum[2:0];
            end
            e2u_pkg::OP_MIN_DIV: begin
                min_next = min_prod[e2u_pkg::MIN_SHIFT +: 6];
            end
            e2u_pkg::OP_MIN_DONE: begin
                sec_next  = 6'(soh_reg - min_back);
                year_next = e2u_pkg::FIRST_YEAR_OFS;
                mon_next  = 4'd0;
            end
            e2u_pkg::OP_YEAR_STEP: begin
                if (sts.year_fit) begin
                    yday_next = days_reg[8:0];
                end else begin
                    days_next = days_reg - {7'd0, ylen};
                    year_next = year_reg + 8'd1;
                end
            end
            e2u_pkg::OP_MONTH_STEP: begin
                if (!sts.month_fit) begin
                    days_next = days_reg - {11'd0, mlen};
                    mon_next  = mon_reg + 4'd1;
                end
            end
            e2u_pkg::OP_PUBLISH: begin
                out_valid_next = 1'b1;
                out_data_next  = {2'b00, dom, mon_reg, yday_reg, year_reg,
                                  wday_reg, hour_reg, min_reg, sec_reg};
            end
            default: begin
            end
        endcase
    end

    // Control register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        t_reg        <= t_next;
        wk_quo_reg   <= wk_quo_next;
        sod_reg      <= sod_next;
        soh_reg      <= soh_next;
        days_reg     <= days_next;
        year_reg     <= year_next;
        yday_reg     <= yday_next;
        mon_reg      <= mon_next;
        sec_reg      <= sec_next;
        min_reg      <= min_next;
        hour_reg     <= hour_next;
        wday_reg     <= wday_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
